/* hdl/sfta_pkg.sv */
// ============================================================================
// sfta_pkg: shared types and constants
// Sync-pattern codes, conversion constants, controller state and the
// command/status structs between controller and datapath.
// ============================================================================
`default_nettype none

package sfta_pkg;

    localparam int MAX_BUFFER_BYTES_DEF = 65536;

    localparam logic [7:0] SYNC_EDGE_BYTE = 8'h0C;
    localparam logic [7:0] SYNC_MID_BYTE  = 8'hFF;

    localparam logic [2:0] WINDOW_FULL = 3'd7;

    localparam int         TEMP_FRAC_BITS = 7;
    localparam logic [6:0] CENTI_PER_DEG  = 7'd100;
    localparam logic signed [15:0] NO_REPORT_AVG = -16'sd9999;
    localparam logic [7:0] SHUTOFF_RESET  = 8'd60;

    typedef enum logic [1:0] {
        ST_SCAN,
        ST_DIVIDE,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic last;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_sts_t;

endpackage

`default_nettype wire

/* hdl/sfta_if.sv */
// ============================================================================
// sfta_if: stream channels
// Byte input channel and result output channel, valid/ready handshake.
// ============================================================================
`default_nettype none

interface sfta_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfta_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] avg_centi_celsius;
    logic               no_reports;
    logic               over_limit;

    modport source (output valid, output avg_centi_celsius, output no_reports,
                    output over_limit, input ready);
    modport sink   (input valid, input avg_centi_celsius, input no_reports,
                    input over_limit, output ready);
endinterface

`default_nettype wire

/* hdl/sfta_datapath.sv */
// ============================================================================
// sfta_datapath: window scan, accumulation and averaging datapath
// Sliding byte window with sync match, centi-degree accumulator, radix-2
// restoring divider and the registered result.
// ============================================================================
`default_nettype none

module sfta_datapath #(
    parameter int MAX_BUFFER_BYTES = sfta_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sfta_pkg::dp_cmd_t  cmd,
    output sfta_pkg::dp_sts_t       sts,
    input  wire logic [7:0]         data_byte,
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data,
    output logic signed [15:0]      avg_centi_celsius,
    output logic                    no_reports,
    output logic                    over_limit
);
    import sfta_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BUFFER_BYTES);
    localparam int SUM_W  = CNT_W + 16;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0]  CNT_CAP   = CNT_W'(MAX_BUFFER_BYTES - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic [7:0]              win_reg [0:6];
    logic [7:0]              win_next [0:6];
    logic [2:0]              fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [7:0]              thr_reg, thr_next;

    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        dvs_reg, dvs_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    neg_reg, neg_next;
    logic                    none_reg, none_next;

    logic signed [15:0]      avg_reg, avg_next;
    logic                    nrep_reg, nrep_next;
    logic                    over_reg, over_next;

    // Sync match and temperature conversion
    logic                    match;
    logic signed [15:0]      raw;
    logic signed [22:0]      prod;
    logic signed [22:0]      prod_adj;
    logic signed [15:0]      centi;
    logic signed [SUM_W-1:0] sum_upd;
    logic [CNT_W-1:0]        cnt_upd;

    // Divider step
    logic [CNT_W:0]          shifted;
    logic [CNT_W:0]          trial;

    // Result
    logic [15:0]             q16;
    logic [8:0]              thr_plus;
    logic [15:0]             limit;

    always_comb
    begin
        match = (fill_reg == WINDOW_FULL)
             && (win_reg[0] == SYNC_EDGE_BYTE) && (win_reg[1] == SYNC_MID_BYTE)
             && (win_reg[2] == SYNC_MID_BYTE)  && (win_reg[3] == SYNC_EDGE_BYTE)
             && (cnt_reg < CNT_CAP);
        raw      = $signed({win_reg[6], data_byte});
        prod     = 23'(raw) * $signed({16'd0, CENTI_PER_DEG});
        // round toward zero before the arithmetic shift
        prod_adj = prod + (prod[22] ? 23'sd127 : 23'sd0);
        centi    = 16'(prod_adj >>> TEMP_FRAC_BITS);
        sum_upd  = sum_reg + (match ? SUM_W'(centi) : '0);
        cnt_upd  = cnt_reg + CNT_W'(match);
    end

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        if (cmd.accept)
        begin
            if (cmd.last)
            begin
                for (int k = 0; k < 7; k++)
                begin
                    win_next[k] = '0;
                end
                fill_next = '0;
                sum_next  = '0;
                cnt_next  = '0;
            end
            else
            begin
                for (int k = 0; k < 6; k++)
                begin
                    win_next[k] = win_reg[k+1];
                end
                win_next[6] = data_byte;
                fill_next   = (fill_reg == WINDOW_FULL) ? fill_reg : fill_reg + 3'd1;
                sum_next    = sum_upd;
                cnt_next    = cnt_upd;
            end
        end
    end

    always_comb
    begin
        thr_next = cfg_wr_en ? cfg_wr_data : thr_reg;
    end

    // Divider: magnitude of the sum over the count, one quotient bit a cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        none_next = none_reg;
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (cmd.accept && cmd.last)
        begin
            neg_next  = sum_upd[SUM_W-1];
            quo_next  = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
            rem_next  = '0;
            dvs_next  = cnt_upd;
            step_next = '0;
            none_next = (cnt_upd == '0);
        end
        else if (cmd.div_step)
        begin
            step_next = step_reg + STEP_W'(1);
            if (!trial[CNT_W])
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        sts.div_last = (step_reg == STEP_LAST);
    end

    // Result: average/100 > T is the same as average >= 100*(T+1)
    always_comb
    begin
        q16       = quo_reg[15:0];
        thr_plus  = {1'b0, thr_reg} + 9'd1;
        limit     = 16'(thr_plus) * 16'(CENTI_PER_DEG);
        avg_next  = avg_reg;
        nrep_next = nrep_reg;
        over_next = over_reg;
        if (cmd.load_out)
        begin
            nrep_next = none_reg;
            if (none_reg)
            begin
                avg_next = NO_REPORT_AVG;
            end
            else if (neg_reg)
            begin
                avg_next = -$signed(q16);
            end
            else
            begin
                avg_next = $signed(q16);
            end
            over_next = !none_reg && !neg_reg && (thr_reg != '0) && (q16 >= limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 7; k++)
            begin
                win_reg[k] <= '0;
            end
            fill_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            thr_reg  <= SHUTOFF_RESET;
            step_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            thr_reg  <= thr_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        none_reg <= none_next;
        avg_reg  <= avg_next;
        nrep_reg <= nrep_next;
        over_reg <= over_next;
    end

    assign avg_centi_celsius = avg_reg;
    assign no_reports        = nrep_reg;
    assign over_limit        = over_reg;

endmodule

`default_nettype wire

/* hdl/sfta_ctrl.sv */
// ============================================================================
// sfta_ctrl: sequencing controller
// Scans bytes, runs the divider after the last byte, and owns the output
// valid flag.
// ============================================================================
`default_nettype none

module sfta_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sfta_pkg::dp_cmd_t       cmd,
    input  wire sfta_pkg::dp_sts_t  sts
);
    import sfta_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    always_comb
    begin
        state_next   = state_reg;
        slot_free    = !out_valid_reg || out_ready;
        in_ready     = (state_reg == ST_SCAN);
        cmd.accept   = 1'b0;
        cmd.last     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_SCAN:
            begin
                cmd.accept = in_valid;
                cmd.last   = in_last;
                if (in_valid && in_last)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase

        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SCAN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/sync_framed_temperature_averager_top.sv */
// ============================================================================
// sync_framed_temperature_averager_top: framed temperature averager
// Scans an instrument buffer for 0C FF FF 0C sync frames and averages the
// temperatures they carry.
// ============================================================================
// Usage:
//   bytes  - input stream, one buffer byte per beat; last_byte marks the end.
//   result - one beat per buffer: average in centi-degrees, no-reports flag
//            and over-limit flag.
//   cfg_wr_en / cfg_wr_data - write the whole-degree shutoff threshold
//            (reset value 60, zero disables the over-limit check).
// Throughput: one byte per cycle while scanning. After the last beat the
//   input stalls for the averaging divide, a radix-2 unit producing one
//   quotient bit per cycle over clog2(MAX_BUFFER_BYTES)+16 bits.
// Result: the divide runs after the last beat is accepted; the result then
//   loads into the output register once any previous result there is taken.
// Reset: clears the window, the sum and count, and restores the threshold.
// Stall: the result sits in the output register until taken; the next
//   buffer is accepted meanwhile, and only the following result waits.
// ============================================================================
`default_nettype none

module sync_framed_temperature_averager_top #(
    parameter int MAX_BUFFER_BYTES = sfta_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    sfta_in_if.sink         bytes,
    sfta_out_if.source      result,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);
    import sfta_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequence scan, divide and result hand-off
    sfta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bytes.valid),
        .in_last   (bytes.last_byte),
        .in_ready  (bytes.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Window match, accumulate, divide and hold the result
    sfta_datapath #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .data_byte         (bytes.data_byte),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .avg_centi_celsius (result.avg_centi_celsius),
        .no_reports        (result.no_reports),
        .over_limit        (result.over_limit)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ============================================================================
// tb_top: framed temperature averager testbench
// Streams instrument buffers through the byte channel and checks every
// result beat against an in-bench model of the sync-frame scan, the
// centi-degree conversion, the averaging divide and the over-limit compare.
// A short table of hand-picked buffers runs first. Random buffers built
// from sync frames, overlapping frames, broken frames and noise follow,
// across several threshold settings. The sender idles in bursts and the
// receiver stalls on a changing pattern.
// ============================================================================
`default_nettype none

module tb_top;

    import sfta_pkg::*;

    // Check window and run-length bounds.
    localparam int          SETTLE_CYCLES  = 40;      // divide latency plus margin
    localparam int          HOLD_OFF_LEN   = 400;     // long receiver stall
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int          PHASE_BYTES    = 84;      // random beats per threshold
    localparam int          NUM_PHASES     = 6;
    localparam int          DIR_ROWS       = 26;
    localparam int          CONV_SCALE     = 100;
    localparam int          CONV_DIV       = 128;

    typedef struct packed {
        logic signed [15:0] avg_centi;
        logic               none;
        logic               over;
    } avg_result_t;

    // One beat of the directed table; typed rows carry their own answer.
    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic               typed;
        logic signed [15:0] avg_centi;
        logic               none;
        logic               over;
    } dir_row_t;

    typedef enum int {
        PC_FRAME,
        PC_OVERLAP,
        PC_BROKEN,
        PC_NOISE
    } piece_kind_t;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    // Directed buffers: a short buffer holding a sync pattern, the largest
    // positive temperature (over the reset threshold), and two overlapping
    // frames whose second one carries the most negative temperature.
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{8'h0C, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h0C, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, -16'sd9999, 1'b1, 1'b0},
        '{8'h0C, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h0C, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hAA, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hBB, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 16'sd25599, 1'b0, 1'b1},
        '{8'h0C, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h0C, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h0C, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h81, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'sd0,     1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b0, 16'sd0,     1'b0, 1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    sfta_in_if  byte_ch ();
    sfta_out_if res_ch ();

    sync_framed_temperature_averager_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (byte_ch),
        .result      (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Scan model: seven previous bytes, fill level, running sum and count,
    // plus the threshold as last written.
    // ------------------------------------------------------------------------
    logic [7:0]  prev_bytes [7];
    int          prev_fill;
    longint      centi_sum;
    int unsigned frame_hits;
    logic [7:0]  limit_deg;

    avg_result_t pending_avgs [$];
    int          err_count;
    int          results_seen;
    int unsigned cycle_count;
    int          burst_left;
    bit          hold_off_req;
    logic [7:0]  stream_q [$];

    // Advance the scan model by one byte; return 1 and the average when the
    // byte closes the buffer.
    function automatic bit fold_byte(input logic [7:0] cur, input logic last,
                                     output avg_result_t res);
        int     raw;
        longint avg;
        res = '0;
        if (prev_fill >= 7 &&
            prev_bytes[0] == SYNC_EDGE_BYTE && prev_bytes[1] == SYNC_MID_BYTE &&
            prev_bytes[2] == SYNC_MID_BYTE && prev_bytes[3] == SYNC_EDGE_BYTE &&
            frame_hits < MAX_BUFFER_BYTES_DEF - 1) begin
            raw = $signed({prev_bytes[6], cur});
            // int division truncates toward zero, as the conversion requires
            centi_sum += (raw * CONV_SCALE) / CONV_DIV;
            frame_hits++;
        end
        for (int k = 0; k < 6; k++)
            prev_bytes[k] = prev_bytes[k + 1];
        prev_bytes[6] = cur;
        if (prev_fill < 7)
            prev_fill++;
        if (!last)
            return 1'b0;
        if (frame_hits == 0) begin
            res.avg_centi = NO_REPORT_AVG;
            res.none      = 1'b1;
            res.over      = 1'b0;
        end
        else begin
            avg           = centi_sum / longint'(frame_hits);
            res.avg_centi = avg[15:0];
            res.none      = 1'b0;
            res.over      = (limit_deg != 0) && (avg / CONV_SCALE > longint'(limit_deg));
        end
        // clear the scan for the next buffer
        for (int k = 0; k < 7; k++)
            prev_bytes[k] = '0;
        prev_fill  = 0;
        centi_sum  = 0;
        frame_hits = 0;
        return 1'b1;
    endfunction

    // Bias toward the sync bytes so partial patterns turn up often.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return SYNC_EDGE_BYTE;
            1:       return SYNC_MID_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    // Raw temperature: uniform, near the current threshold, extremes, or
    // small values around zero where truncation direction matters.
    function automatic logic [15:0] pick_raw();
        int v;
        case ($urandom_range(0, 3))
            0: v = $signed(16'($urandom));
            1: v = int'(limit_deg) * CONV_DIV + $urandom_range(0, 1024) - 512;
            2: begin
                case ($urandom_range(0, 4))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = -1;
                    3:       v = 1;
                    default: v = 0;
                endcase
            end
            default: v = $urandom_range(0, 1200) - 600;
        endcase
        if (v > 32767)
            v = 32767;
        return v[15:0];
    endfunction

    // Offer one beat and hold it until the handshake; open a random gap
    // first whenever the current burst has run out.
    task automatic send_beat(input logic [7:0] d, input logic l,
                             output bit got, output avg_result_t res);
        if (burst_left == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // now and then a long stretch with no idling at all
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= d;
        byte_ch.last_byte <= l;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        burst_left--;
        got = fold_byte(d, l, res);
    endtask

    // Drop valid, wait until every expected beat has been taken, then let
    // the block run out its latency.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (pending_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each taken beat with the oldest expectation.
    // Signals are read at the edge, before any update of this step lands.
    // ------------------------------------------------------------------------
    avg_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (pending_avgs.size() == 0) begin
                $error("result beat with no expectation: avg %0d no_reports %0b over %0b",
                       res_ch.avg_centi_celsius, res_ch.no_reports, res_ch.over_limit);
                err_count++;
            end
            else begin
                want = pending_avgs.pop_front();
                if (res_ch.avg_centi_celsius !== want.avg_centi) begin
                    $error("avg_centi_celsius: expected %0d, got %0d",
                           want.avg_centi, res_ch.avg_centi_celsius);
                    err_count++;
                end
                if (res_ch.no_reports !== want.none) begin
                    $error("no_reports: expected %0b, got %0b",
                           want.none, res_ch.no_reports);
                    err_count++;
                end
                if (res_ch.over_limit !== want.over) begin
                    $error("over_limit: expected %0b, got %0b",
                           want.over, res_ch.over_limit);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a mode that changes after a random span.
    // Once asked, hold ready low for a long stretch so the output register
    // and the next buffer back up into the byte channel.
    // ------------------------------------------------------------------------
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       hold_left;
        bit       hold_done;
        mode      = RX_FREE;
        span      = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                for (hold_left = HOLD_OFF_LEN; hold_left > 0; hold_left--)
                    @(posedge clk);
            end
            else begin
                if (span == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(16, 96);
                end
                span--;
                case (mode)
                    RX_FREE:   res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= 1'($urandom);
                    RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   res_ch.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, then random buffers per threshold.
    // ------------------------------------------------------------------------
    initial
    begin
        bit          got;
        avg_result_t res;
        piece_kind_t kind;
        logic [15:0] t1;
        logic [15:0] t2;
        logic [7:0]  phase_limit;
        int          phase_items;
        int          pieces;
        int          slot;

        // every input known from time zero
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.last_byte   <= 1'b0;

        for (int k = 0; k < 7; k++)
            prev_bytes[k] = '0;
        prev_fill    = 0;
        centi_sum    = 0;
        frame_hits   = 0;
        limit_deg    = SHUTOFF_RESET;
        err_count    = 0;
        results_seen = 0;
        cycle_count  = 0;
        burst_left   = 0;
        hold_off_req = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs on the reset threshold. Typed rows use their
        // own answer; the model still folds them to keep its state in step.
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_beat(DIR_TAB[r].data, DIR_TAB[r].last, got, res);
            if (got) begin
                if (DIR_TAB[r].typed) begin
                    res.avg_centi = DIR_TAB[r].avg_centi;
                    res.none      = DIR_TAB[r].none;
                    res.over      = DIR_TAB[r].over;
                end
                pending_avgs.push_back(res);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Sender pauses here until every result is in.
            settle();
            case (phase)
                0:       phase_limit = 8'd0;      // check disabled
                1:       phase_limit = 8'd255;
                2:       phase_limit = 8'd1;
                5:       phase_limit = SHUTOFF_RESET;
                default: phase_limit = 8'($urandom_range(2, 254));
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_limit;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            limit_deg    = phase_limit;
            if (phase == 2)
                hold_off_req = 1'b1;

            phase_items = 0;
            while (phase_items < PHASE_BYTES) begin
                // Build one buffer: mostly sync frames with random payload,
                // with overlapping frames, broken patterns and noise mixed in.
                stream_q.delete();
                if ($urandom_range(0, 9) == 0) begin
                    // short buffer, too few bytes for any window to fill
                    repeat ($urandom_range(1, 7))
                        stream_q.push_back(noise_byte());
                end
                else begin
                    pieces = $urandom_range(0, 5);
                    repeat (pieces) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: kind = PC_FRAME;
                            5:             kind = PC_OVERLAP;
                            6, 7:          kind = PC_BROKEN;
                            default:       kind = PC_NOISE;
                        endcase
                        t1 = pick_raw();
                        t2 = pick_raw();
                        case (kind)
                            PC_FRAME, PC_BROKEN: begin
                                stream_q.push_back(SYNC_EDGE_BYTE);
                                stream_q.push_back(SYNC_MID_BYTE);
                                stream_q.push_back(SYNC_MID_BYTE);
                                stream_q.push_back(SYNC_EDGE_BYTE);
                                if (kind == PC_BROKEN) begin
                                    slot = stream_q.size() - 1 - $urandom_range(0, 3);
                                    stream_q[slot] = 8'($urandom);
                                end
                                stream_q.push_back(8'($urandom));
                                stream_q.push_back(8'($urandom));
                                stream_q.push_back(t1[15:8]);
                                stream_q.push_back(t1[7:0]);
                            end
                            PC_OVERLAP: begin
                                // second sync starts on the fourth byte of the
                                // first; its temperature comes three beats later
                                stream_q.push_back(SYNC_EDGE_BYTE);
                                stream_q.push_back(SYNC_MID_BYTE);
                                stream_q.push_back(SYNC_MID_BYTE);
                                stream_q.push_back(SYNC_EDGE_BYTE);
                                stream_q.push_back(SYNC_MID_BYTE);
                                stream_q.push_back(SYNC_MID_BYTE);
                                stream_q.push_back(SYNC_EDGE_BYTE);
                                stream_q.push_back(t1[7:0]);
                                stream_q.push_back(8'($urandom));
                                stream_q.push_back(t2[15:8]);
                                stream_q.push_back(t2[7:0]);
                            end
                            default: begin
                                repeat ($urandom_range(1, 4))
                                    stream_q.push_back(noise_byte());
                            end
                        endcase
                    end
                    if (stream_q.size() == 0)
                        stream_q.push_back(8'($urandom));
                end

                for (int k = 0; k < stream_q.size(); k++) begin
                    send_beat(stream_q[k], k == stream_q.size() - 1, got, res);
                    if (got)
                        pending_avgs.push_back(res);
                end
                phase_items += stream_q.size();
            end
        end

        // Drain: every result in, then a latency's worth of quiet cycles so
        // a stray beat would still be caught.
        settle();
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
